FILE: design/istl_pkg.sv
// Shared constants, codes and types of the interpolated spectrum table lookup.
// Used by istl_ram users and the top level; depends on nothing.
package istl_pkg;

  localparam int MAX_ROWS     = 256;
  localparam int MAX_CURVES   = 16;
  localparam int ROW_W        = $clog2(MAX_ROWS);
  localparam int ROW_CNT_W    = $clog2(MAX_ROWS + 1);
  localparam int CURVE_CNT_W  = $clog2(MAX_CURVES + 1);
  localparam int VAL_DEPTH    = MAX_CURVES * MAX_ROWS;
  localparam int VAL_AW       = $clog2(VAL_DEPTH);
  localparam int WL_W         = 16;
  localparam int VAL_W        = 16;
  localparam int PROD_W       = 2 * VAL_W;
  localparam int DIV_CNT_W    = $clog2(VAL_W);
  localparam int ROWS_CFG_W   = 9;
  localparam int CURVES_CFG_W = 5;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 9;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CURVES = 1'b1;

  typedef enum logic [1:0] {
    FN_WR_WL  = 2'd0,
    FN_WR_VAL = 2'd1,
    FN_QUERY  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CURVE = 2'd1,
    ST_EMPTY     = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_RD_ONE,
    S_ONE_WAIT,
    S_RD_LO,
    S_RD_HI,
    S_MUL_LO,
    S_MUL_HI,
    S_DIV,
    S_DONE
  } state_t;

endpackage

FILE: design/istl_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Standalone; no package needed.
module istl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/interpolated_spectrum_table_lookup_unit.sv
// Interpolated spectrum table lookup: a row wavelength table and a curve value table in two
// RAMs (istl_ram), a scan sequencer and one shared 16x16 multiplier / restoring divider.
// Depends on istl_pkg and istl_ram.
//
// Write beats (row wavelength or curve value) write the RAMs on acceptance. A query scans the
// wavelength RAM once, one row per cycle through its single read port. An exact match or
// clamped point then reads one value; an interpolated point takes two value reads, two
// passes through the shared multiplier and sixteen restoring divide steps. A bad curve
// index or an empty table answers without a scan.
// The block takes one item at a time; in_ready is high only while the sequencer is idle,
// and a finished result waits in the output register while the next item is taken. The
// tables are not cleared at reset and must be written before being queried.
module interpolated_spectrum_table_lookup_unit
  import istl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_func,
  input  logic [7:0]            in_row,
  input  logic [7:0]            in_curve,
  input  logic [WL_W-1:0]       in_wavelength,
  input  logic [VAL_W-1:0]      in_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VAL_W-1:0]      out_value,
  output logic [1:0]            out_status,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // control state
  state_t                    state_r, state_nxt;
  logic [ROWS_CFG_W-1:0]     rows_r;
  logic [CURVES_CFG_W-1:0]   curves_r;
  logic                      rd_vld_r, rd_vld_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // query payload
  logic [ROW_CNT_W-1:0]      n_r, n_nxt;
  logic [ROW_W-1:0]          last_r, last_nxt;
  logic [WL_W-1:0]           q_r, q_nxt;
  logic [7:0]                curve_r, curve_nxt;
  logic [ROW_CNT_W-1:0]      issue_r, issue_nxt;
  logic [ROW_W-1:0]          rd_idx_r, rd_idx_nxt;
  logic                      hit_r, hit_nxt;
  logic [ROW_W-1:0]          hit_idx_r, hit_idx_nxt;
  logic [WL_W-1:0]           w0_r, w0_nxt;
  logic [WL_W-1:0]           wlast_r, wlast_nxt;
  logic [WL_W-1:0]           prev_r, prev_nxt;
  logic                      pfound_r, pfound_nxt;
  logic [ROW_W-1:0]          p_r, p_nxt;
  logic [WL_W-1:0]           whi_r, whi_nxt;
  logic [WL_W-1:0]           wlo_r, wlo_nxt;
  logic [WL_W-1:0]           dh_r, dh_nxt;
  logic [WL_W-1:0]           dl_r, dl_nxt;
  logic [WL_W-1:0]           d_r, d_nxt;
  logic [ROW_W-1:0]          one_idx_r, one_idx_nxt;
  logic [VAL_W-1:0]          vlo_r, vlo_nxt;
  logic [VAL_W-1:0]          vhi_r, vhi_nxt;
  logic [PROD_W-1:0]         acc_r, acc_nxt;
  logic [DIV_CNT_W-1:0]      div_cnt_r, div_cnt_nxt;
  logic [VAL_W-1:0]          res_value_r, res_value_nxt;
  status_t                   res_status_r, res_status_nxt;
  logic [VAL_W-1:0]          out_value_r, out_value_nxt;
  status_t                   out_status_r, out_status_nxt;

  // RAM ports
  logic                      wl_we;
  logic [ROW_W-1:0]          wl_raddr;
  logic [WL_W-1:0]           wl_rdata;
  logic                      val_we;
  logic [VAL_AW-1:0]         val_waddr;
  logic [VAL_AW-1:0]         val_raddr;
  logic [VAL_W-1:0]          val_rdata;
  logic [ROW_W-1:0]          val_rrow;

  // shared arithmetic
  logic [VAL_W-1:0]          mul_a;
  logic [WL_W-1:0]           mul_b;
  logic [PROD_W-1:0]         prod;
  logic [VAL_W:0]            div_try;
  logic                      div_ge;
  logic [VAL_W:0]            div_rem;

  logic                      accept;
  logic [ROW_CNT_W-1:0]      n_eff;
  logic [CURVE_CNT_W-1:0]    nc_eff;

  istl_ram #(.WIDTH(WL_W), .DEPTH(MAX_ROWS)) u_wl_ram (
    .clk   (clk),
    .we    (wl_we),
    .waddr (in_row[ROW_W-1:0]),
    .wdata (in_wavelength),
    .raddr (wl_raddr),
    .rdata (wl_rdata)
  );

  istl_ram #(.WIDTH(VAL_W), .DEPTH(VAL_DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (in_sample),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  assign n_eff  = (32'(rows_r) > MAX_ROWS) ? ROW_CNT_W'(MAX_ROWS) : ROW_CNT_W'(rows_r);
  assign nc_eff = (32'(curves_r) > MAX_CURVES) ? CURVE_CNT_W'(MAX_CURVES)
                                               : CURVE_CNT_W'(curves_r);

  assign wl_we     = accept && (in_func == FN_WR_WL) && (32'(in_row) < MAX_ROWS);
  assign val_we    = accept && (in_func == FN_WR_VAL) && (32'(in_row) < MAX_ROWS)
                     && (32'(in_curve) < MAX_CURVES);
  assign val_waddr = VAL_AW'(32'(in_curve) * MAX_ROWS + 32'(in_row));
  assign wl_raddr  = issue_r[ROW_W-1:0];

  always_comb begin
    unique case (state_r)
      S_RD_LO: val_rrow = p_r - ROW_W'(1);
      S_RD_HI: val_rrow = p_r;
      default: val_rrow = one_idx_r;
    endcase
  end
  assign val_raddr = VAL_AW'(32'(curve_r) * MAX_ROWS + 32'(val_rrow));

  // one multiplier, shared by both interpolation terms
  assign mul_a = (state_r == S_MUL_LO) ? vlo_r : vhi_r;
  assign mul_b = (state_r == S_MUL_LO) ? dh_r : dl_r;
  assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

  // restoring divide step: remainder in acc_r upper half, quotient shifts into lower half
  assign div_try = {acc_r[PROD_W-1:VAL_W], acc_r[VAL_W-1]};
  assign div_ge  = (div_try >= {1'b0, d_r});
  assign div_rem = div_ge ? (div_try - {1'b0, d_r}) : div_try;

  always_comb begin
    state_nxt      = state_r;
    rd_vld_nxt     = rd_vld_r;
    out_valid_nxt  = out_valid_r;
    n_nxt          = n_r;
    last_nxt       = last_r;
    q_nxt          = q_r;
    curve_nxt      = curve_r;
    issue_nxt      = issue_r;
    rd_idx_nxt     = rd_idx_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    w0_nxt         = w0_r;
    wlast_nxt      = wlast_r;
    prev_nxt       = prev_r;
    pfound_nxt     = pfound_r;
    p_nxt          = p_r;
    whi_nxt        = whi_r;
    wlo_nxt        = wlo_r;
    dh_nxt         = dh_r;
    dl_nxt         = dl_r;
    d_nxt          = d_r;
    one_idx_nxt    = one_idx_r;
    vlo_nxt        = vlo_r;
    vhi_nxt        = vhi_r;
    acc_nxt        = acc_r;
    div_cnt_nxt    = div_cnt_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;

    // drop the output beat once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_func == FN_QUERY)) begin
          curve_nxt   = in_curve;
          q_nxt       = in_wavelength;
          n_nxt       = n_eff;
          last_nxt    = ROW_W'(n_eff - ROW_CNT_W'(1));
          issue_nxt   = '0;
          rd_vld_nxt  = 1'b0;
          hit_nxt     = 1'b0;
          pfound_nxt  = 1'b0;
          if (32'(in_curve) >= 32'(nc_eff)) begin
            res_value_nxt  = '0;
            res_status_nxt = ST_BAD_CURVE;
            state_nxt      = S_DONE;
          end else if (n_eff == '0) begin
            res_value_nxt  = '0;
            res_status_nxt = ST_EMPTY;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (issue_r < n_r) begin
          issue_nxt  = issue_r + ROW_CNT_W'(1);
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = issue_r[ROW_W-1:0];
        end else begin
          rd_vld_nxt = 1'b0;
        end
        if (rd_vld_r) begin
          prev_nxt = wl_rdata;
          if (rd_idx_r == '0) begin
            w0_nxt = wl_rdata;
          end
          if (!hit_r && (wl_rdata == q_r)) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = rd_idx_r;
          end
          // upper bracket: first inner row above the point, else the last row
          if (!pfound_r && (rd_idx_r != '0) && ((rd_idx_r == last_r) || (wl_rdata > q_r)))
          begin
            pfound_nxt = 1'b1;
            p_nxt      = rd_idx_r;
            whi_nxt    = wl_rdata;
            wlo_nxt    = prev_r;
          end
          if (rd_idx_r == last_r) begin
            wlast_nxt  = wl_rdata;
            rd_vld_nxt = 1'b0;
            state_nxt  = S_DECIDE;
          end
        end
      end

      S_DECIDE: begin
        res_status_nxt = ST_OK;
        dh_nxt         = whi_r - q_r;
        dl_nxt         = q_r - wlo_r;
        d_nxt          = whi_r - wlo_r;
        priority if (hit_r) begin
          one_idx_nxt = hit_idx_r;
          state_nxt   = S_RD_ONE;
        end else if (q_r < w0_r) begin
          one_idx_nxt = '0;
          state_nxt   = S_RD_ONE;
        end else if (q_r > wlast_r) begin
          one_idx_nxt = last_r;
          state_nxt   = S_RD_ONE;
        end else begin
          state_nxt = S_RD_LO;
        end
      end

      S_RD_ONE: begin
        state_nxt = S_ONE_WAIT;
      end

      S_ONE_WAIT: begin
        res_value_nxt = val_rdata;
        state_nxt     = S_DONE;
      end

      S_RD_LO: begin
        state_nxt = S_RD_HI;
      end

      S_RD_HI: begin
        vlo_nxt   = val_rdata;
        state_nxt = S_MUL_LO;
      end

      S_MUL_LO: begin
        vhi_nxt   = val_rdata;
        acc_nxt   = prod;
        state_nxt = S_MUL_HI;
      end

      S_MUL_HI: begin
        acc_nxt     = acc_r + prod;
        div_cnt_nxt = '0;
        state_nxt   = S_DIV;
      end

      S_DIV: begin
        acc_nxt     = {div_rem[VAL_W-1:0], acc_r[VAL_W-2:0], div_ge};
        div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        if (div_cnt_r == DIV_CNT_W'(VAL_W - 1)) begin
          res_value_nxt = acc_nxt[VAL_W-1:0];
          state_nxt     = S_DONE;
        end
      end

      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      rows_r      <= '0;
      curves_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROWS:   rows_r   <= cfg_data[ROWS_CFG_W-1:0];
          REG_CURVES: curves_r <= cfg_data[CURVES_CFG_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    last_r       <= last_nxt;
    q_r          <= q_nxt;
    curve_r      <= curve_nxt;
    issue_r      <= issue_nxt;
    rd_idx_r     <= rd_idx_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    w0_r         <= w0_nxt;
    wlast_r      <= wlast_nxt;
    prev_r       <= prev_nxt;
    pfound_r     <= pfound_nxt;
    p_r          <= p_nxt;
    whi_r        <= whi_nxt;
    wlo_r        <= wlo_nxt;
    dh_r         <= dh_nxt;
    dl_r         <= dl_nxt;
    d_r          <= d_nxt;
    one_idx_r    <= one_idx_nxt;
    vlo_r        <= vlo_nxt;
    vhi_r        <= vhi_nxt;
    acc_r        <= acc_nxt;
    div_cnt_r    <= div_cnt_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

`ifndef ASSERT_OFF
  a_div_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (acc_r[PROD_W-1:VAL_W] < d_r))
    else $error("divide remainder not below divisor");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (d_r != '0))
    else $error("interpolation divisor is zero");

  a_no_wl_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (!wl_we && !val_we))
    else $error("table written during a query");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result beat raised outside the done state");
`endif

endmodule
